FILE: rtl/core/slx_pkg.sv
// Shared types and constants for the start/length/XOR frame receiver.
// No dependencies.
package slx_pkg;

  localparam int BYTE_W   = 8;
  localparam int STATUS_W = 3;
  localparam int CFG_IDX_W = 1;

  // Result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_IN_FRAME = 3'd0,
    ST_GOOD     = 3'd1,
    ST_CSUM_ERR = 3'd2,
    ST_LEN_ERR  = 3'd3,
    ST_DISCARD  = 3'd4
  } frame_status_t;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_START_BYTE    = 1'd0,
    REG_CHECKSUM_SEED = 1'd1
  } cfg_reg_t;

  // Receiver phase, one-hot
  typedef enum logic [3:0] {
    PH_HUNT = 4'b0001,
    PH_LEN  = 4'b0010,
    PH_DATA = 4'b0100,
    PH_CHK  = 4'b1000
  } phase_t;

  localparam logic [BYTE_W-1:0] START_BYTE_RST    = 8'd177;
  localparam logic [BYTE_W-1:0] CHECKSUM_SEED_RST = 8'd255;

endpackage

FILE: rtl/core/slx_stream_if.sv
// Valid/ready channel interfaces for the frame receiver: received bytes in,
// per-byte results out. Depends on slx_pkg.
interface slx_in_if;
  import slx_pkg::*;

  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface slx_out_if;
  import slx_pkg::*;

  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] data_byte;
  logic [BYTE_W-1:0] position;
  frame_status_t     frame_status;
  logic              last;

  modport source (output valid, output data_byte, output position,
                  output frame_status, output last, input ready);
  modport sink   (input valid, input data_byte, input position,
                  input frame_status, input last, output ready);
endinterface

FILE: rtl/core/start_length_xor_frame_receiver.sv
// Start-byte / length / XOR-checksum frame receiver, top level.
// A byte passes the input register, then the result register, before it is
// offered on out_ch.
// Throughput: one byte per cycle while the output is not stalled; a stalled result
// register holds one item while the input register takes the next.
// Reset (rst_n, synchronous, active low): hunting, counters and checksum
// cleared, start_byte = 177, checksum_seed = 255, both registers empty.
// Depends on slx_pkg and slx_stream_if.
module start_length_xor_frame_receiver #(
  parameter int MAX_FRAME = 64   // 4 .. 256 bytes, start to checksum
) (
  input  logic                           clk,
  input  logic                           rst_n,
  slx_in_if.sink                         in_ch,
  slx_out_if.source                      out_ch,
  input  logic                           cfg_we,
  input  logic [slx_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [slx_pkg::BYTE_W-1:0]     cfg_data
);
  import slx_pkg::*;

  // Longest legal length byte: the frame is L + 2 bytes in total
  localparam int MAX_LEN = MAX_FRAME - 2;

  // Configuration registers
  logic [BYTE_W-1:0] start_byte_r;
  logic [BYTE_W-1:0] checksum_seed_r;

  // Input register
  logic              in_vld_r;
  logic [BYTE_W-1:0] in_byte_r;

  // Frame state
  phase_t            phase_r,    phase_nxt;
  logic [BYTE_W-1:0] byte_pos_r, byte_pos_nxt;
  logic [BYTE_W-1:0] frame_len_r, frame_len_nxt;
  logic [BYTE_W-1:0] run_xor_r,  run_xor_nxt;

  // Result register
  logic              out_vld_r;
  logic [BYTE_W-1:0] out_byte_r;
  logic [BYTE_W-1:0] out_pos_r,  out_pos_nxt;
  frame_status_t     out_stat_r, out_stat_nxt;
  logic              out_last_r, out_last_nxt;

  logic advance;   // input register moves into the result register
  logic in_fire;
  logic len_bad;

  assign advance  = in_vld_r && (!out_vld_r || out_ch.ready);
  assign in_ch.ready = !in_vld_r || advance;
  assign in_fire  = in_ch.valid && in_ch.ready;

  // Length 0, or longer than MAX_LEN
  assign len_bad = (in_byte_r == '0) ||
                   ({1'b0, in_byte_r} > (BYTE_W+1)'(MAX_LEN));

  // ---- per-byte frame decode ----
  always_comb begin
    phase_nxt     = phase_r;
    byte_pos_nxt  = byte_pos_r;
    frame_len_nxt = frame_len_r;
    run_xor_nxt   = run_xor_r;
    out_pos_nxt   = '0;
    out_stat_nxt  = ST_IN_FRAME;
    out_last_nxt  = 1'b0;
    case (phase_r)
      PH_LEN: begin
        out_pos_nxt   = 8'd1;
        frame_len_nxt = in_byte_r;
        if (len_bad) begin
          out_stat_nxt = ST_LEN_ERR;
          out_last_nxt = 1'b1;
          phase_nxt    = PH_HUNT;
          byte_pos_nxt = '0;
        end else begin
          // length of one: no data, checksum byte follows directly
          phase_nxt    = (in_byte_r == 8'd1) ? PH_CHK : PH_DATA;
          byte_pos_nxt = 8'd2;
        end
      end
      PH_DATA: begin
        out_pos_nxt  = byte_pos_r;
        run_xor_nxt  = run_xor_r ^ in_byte_r;
        if (byte_pos_r == frame_len_r) begin
          phase_nxt = PH_CHK;
        end
        byte_pos_nxt = byte_pos_r + 8'd1;
      end
      PH_CHK: begin
        out_pos_nxt  = byte_pos_r;
        out_stat_nxt = (in_byte_r == run_xor_r) ? ST_GOOD : ST_CSUM_ERR;
        out_last_nxt = 1'b1;
        phase_nxt    = PH_HUNT;
        byte_pos_nxt = '0;
      end
      default: begin
        // hunting: anything but the start byte is passed on as ST_DISCARD
        if (in_byte_r == start_byte_r) begin
          run_xor_nxt  = checksum_seed_r;   // seed sampled at frame start
          phase_nxt    = PH_LEN;
          byte_pos_nxt = 8'd1;
        end else begin
          out_stat_nxt = ST_DISCARD;
          byte_pos_nxt = '0;
        end
      end
    endcase
  end

  // ---- configuration ----
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_byte_r    <= START_BYTE_RST;
      checksum_seed_r <= CHECKSUM_SEED_RST;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_START_BYTE:    start_byte_r    <= cfg_data;
        REG_CHECKSUM_SEED: checksum_seed_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // ---- control and state ----
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r    <= 1'b0;
      out_vld_r   <= 1'b0;
      phase_r     <= PH_HUNT;
      byte_pos_r  <= '0;
      frame_len_r <= '0;
      run_xor_r   <= '0;
    end else begin
      if (in_fire) begin
        in_vld_r <= 1'b1;
      end else if (advance) begin
        in_vld_r <= 1'b0;
      end
      if (advance) begin
        out_vld_r   <= 1'b1;
        phase_r     <= phase_nxt;
        byte_pos_r  <= byte_pos_nxt;
        frame_len_r <= frame_len_nxt;
        run_xor_r   <= run_xor_nxt;
      end else if (out_ch.ready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  // ---- payload ----
  always_ff @(posedge clk) begin
    if (in_fire) begin
      in_byte_r <= in_ch.rx_byte;
    end
    if (advance) begin
      out_byte_r <= in_byte_r;
      out_pos_r  <= out_pos_nxt;
      out_stat_r <= out_stat_nxt;
      out_last_r <= out_last_nxt;
    end
  end

  assign out_ch.valid        = out_vld_r;
  assign out_ch.data_byte    = out_byte_r;
  assign out_ch.position     = out_pos_r;
  assign out_ch.frame_status = out_stat_r;
  assign out_ch.last         = out_last_r;

endmodule
